/* sv/boundary_tag_heap_allocator_macros.svh */
// ---------------------------------------------------------------------------
// boundary tag heap allocator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH

// property that must hold at every edge
`define BTH_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define BTH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bth_pkg.sv */
// ---------------------------------------------------------------------------
// bth_pkg
// types, codes and constants of the boundary tag heap allocator
// ---------------------------------------------------------------------------
package bth_pkg;

    localparam int HEAP_WORDS_DEF = 16384;
    localparam int CHUNK_W        = 17;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;
    localparam int WSIZE          = 4;
    localparam int DSIZE          = 8;
    localparam int MIN_BLOCK      = 2 * DSIZE;
    localparam int FIRST_BLOCK    = 8;
    localparam int PROLOGUE_TAG   = 9;
    localparam int EPILOGUE_TAG   = 1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] block_address;
        logic [15:0] request_bytes;
    } t_in;

    typedef struct packed {
        logic [15:0] result_address;
        logic [1:0]  status;
        logic [15:0] copy_source;
        logic [15:0] copy_destination;
        logic [15:0] copy_bytes;
    } t_out;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_INIT2,
        S_GR_CHK, S_GR_W0, S_GR_W1, S_GR_W2,
        S_MG_RDP, S_MG_RDN, S_MG_CK, S_MG_W0, S_MG_W1,
        S_IDLE,
        S_ISA_RD, S_ISA_CK, S_ISA_END,
        S_FF1_RD, S_FF1_CK, S_FF2_RD, S_FF2_CK, S_FFE_CK,
        S_PL_W0, S_PL_W1, S_PL_W2, S_PL_W3,
        S_RL_W0, S_RL_W1,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        K_INIT, K_ALLOC, K_FREE, K_RSHR, K_RMOVE
    } t_kind;

endpackage

/* sv/bth_tag_ram.sv */
// ---------------------------------------------------------------------------
// bth_tag_ram
// tag word memory, one write and one registered read per cycle,
// a write to the address being read is forwarded
// ---------------------------------------------------------------------------
module bth_tag_ram #(
    parameter int WORDS = bth_pkg::HEAP_WORDS_DEF,
    parameter int AW    = $clog2(bth_pkg::HEAP_WORDS_DEF),
    parameter int DW    = $clog2(bth_pkg::HEAP_WORDS_DEF) + 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [WORDS];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/boundary_tag_heap_allocator.sv */
// ---------------------------------------------------------------------------
// boundary_tag_heap_allocator
// implicit free list heap with boundary tags and next-fit search
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      i_in_valid/o_in_stall  i_in_data  (bth_pkg::t_in)
//  out      output     o_out_valid/i_out_stall o_out_data (bth_pkg::t_out)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (extend chunk bytes)
//
//  each visited block header takes a read state and a check state at the tag memory read port;
//  allocate walks the headers, grows the heap if none fits, then places and may split the block;
//  free walks the headers up to the block, then releases it, merges it and finishes;
//  reallocate walks the same way, then shrinks in place or allocates and releases the old block
//  after reset o_in_stall stays high while the heap is built (its first chunk only if it fits).
//  a result waits in the output register while the next request is taken; it leaves only
//  when i_out_stall is low, and the next result waits for it in the finishing state.
// ---------------------------------------------------------------------------
`include "boundary_tag_heap_allocator_macros.svh"

module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = bth_pkg::HEAP_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bth_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bth_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bth_pkg::CHUNK_W-1:0]   i_cfg_data
);

    localparam int WW = $clog2(HEAP_WORDS);
    localparam int BW = WW + 3;
    localparam int XW = ((BW > 18) ? BW : 18) + 1;
    localparam logic [XW-1:0] HEAP_BYTES = XW'(HEAP_WORDS) << 2;
    localparam logic [XW-1:0] W4  = XW'(bth_pkg::WSIZE);
    localparam logic [XW-1:0] D8  = XW'(bth_pkg::DSIZE);
    localparam logic [XW-1:0] MIN = XW'(bth_pkg::MIN_BLOCK);
    localparam logic [XW-1:0] FIRST = XW'(bth_pkg::FIRST_BLOCK);

    bth_pkg::t_state r_state, n_state;
    bth_pkg::t_kind  r_kind, n_kind;
    logic            r_rel, n_rel;
    logic            r_ok, n_ok;
    logic [XW-1:0]   r_addr, n_addr;
    logic [XW-1:0]   r_req, n_req;
    logic [XW-1:0]   r_asize, n_asize;
    logic [XW-1:0]   r_osize, n_osize;
    logic [XW-1:0]   r_bp, n_bp;
    logic [XW-1:0]   r_fsize, n_fsize;
    logic [XW-1:0]   r_b, n_b;
    logic [XW-1:0]   r_rover, n_rover;
    logic [XW-1:0]   r_old, n_old;
    logic [XW-1:0]   r_brk, n_brk;
    logic [XW-1:0]   r_gbytes, n_gbytes;
    logic [XW-1:0]   r_gsize, n_gsize;
    logic [BW-1:0]   r_prev, n_prev;
    logic [bth_pkg::CHUNK_W-1:0] r_chunk;
    logic [15:0]     r_res, n_res;
    logic [1:0]      r_st, n_st;
    logic [15:0]     r_src, n_src;
    logic [15:0]     r_dst, n_dst;
    logic [15:0]     r_cnt, n_cnt;
    bth_pkg::t_out   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            w_we;
    logic [XW-1:0]   w_wr_byte, w_wr_val, w_rd_byte;
    logic [BW-1:0]   w_rdata;
    logic [XW-1:0]   w_rsize, w_psize, w_nsize_add, w_psize_add;
    logic            w_ralloc, w_palloc;
    logic            w_split, w_fits;
    logic [XW-1:0]   w_first_sz, w_rem;
    logic [XW-1:0]   w_gsize, w_grow_end;
    logic [XW-1:0]   w_total, w_start, w_cnt_full;
    logic [XW-1:0]   w_asize_alloc, w_asize_real, w_chunk_x;

    bth_tag_ram #(
        .WORDS (HEAP_WORDS),
        .AW    (WW),
        .DW    (BW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_byte[WW+1:2]),
        .i_wdata (w_wr_val[BW-1:0]),
        .i_raddr (w_rd_byte[WW+1:2]),
        .o_rdata (w_rdata)
    );

    assign w_rsize  = XW'({w_rdata[BW-1:3], 3'b000});
    assign w_ralloc = w_rdata[0];
    assign w_psize  = XW'({r_prev[BW-1:3], 3'b000});
    assign w_palloc = r_prev[0];
    assign w_split  = r_fsize >= (r_asize + MIN);
    assign w_first_sz = w_split ? r_asize : r_fsize;
    assign w_rem    = r_fsize - r_asize;
    assign w_fits   = !w_ralloc && (r_asize <= w_rsize);
    // growth rounds bytes / 4 up to an even word count
    assign w_gsize    = (((r_gbytes >> 2) + XW'(1)) & ~XW'(1)) << 2;
    assign w_grow_end = r_brk + w_gsize;
    assign w_nsize_add = w_ralloc ? '0 : w_rsize;
    assign w_psize_add = w_palloc ? '0 : w_psize;
    assign w_total    = r_fsize + w_nsize_add + w_psize_add;
    assign w_start    = w_palloc ? r_bp : (r_bp - w_psize);
    assign w_cnt_full = r_osize - D8;
    assign w_chunk_x  = XW'(r_chunk);
    assign w_asize_real  = (XW'(i_in_data.request_bytes) + XW'(15)) & ~XW'(7);
    assign w_asize_alloc = (i_in_data.request_bytes <= 16'd8) ? MIN : w_asize_real;

    assign o_in_stall  = (r_state != bth_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bth_pkg::S_INIT0;
            r_kind      <= bth_pkg::K_INIT;
            r_rel       <= 1'b0;
            r_out_valid <= 1'b0;
            r_brk       <= XW'(16);
            r_rover     <= FIRST;
            r_chunk     <= bth_pkg::CHUNK_RESET;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_rel       <= n_rel;
            r_out_valid <= n_out_valid;
            r_brk       <= n_brk;
            r_rover     <= n_rover;
            if (i_cfg_valid && o_cfg_ready) begin
                r_chunk <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok     <= n_ok;
        r_addr   <= n_addr;
        r_req    <= n_req;
        r_asize  <= n_asize;
        r_osize  <= n_osize;
        r_bp     <= n_bp;
        r_fsize  <= n_fsize;
        r_b      <= n_b;
        r_old    <= n_old;
        r_gbytes <= n_gbytes;
        r_gsize  <= n_gsize;
        r_prev   <= n_prev;
        r_res    <= n_res;
        r_st     <= n_st;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    always_comb begin
        n_state = r_state;   n_kind = r_kind;     n_rel = r_rel;     n_ok = r_ok;
        n_addr = r_addr;     n_req = r_req;       n_asize = r_asize; n_osize = r_osize;
        n_bp = r_bp;         n_fsize = r_fsize;   n_b = r_b;         n_rover = r_rover;
        n_old = r_old;       n_brk = r_brk;       n_gbytes = r_gbytes;
        n_gsize = r_gsize;   n_prev = r_prev;
        n_res = r_res;       n_st = r_st;         n_src = r_src;     n_dst = r_dst;
        n_cnt = r_cnt;       n_out = r_out;       n_out_valid = r_out_valid;
        w_we = 1'b0;         w_wr_byte = '0;      w_wr_val = '0;     w_rd_byte = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bth_pkg::S_INIT0: begin
                w_we = 1'b1; w_wr_byte = XW'(4); w_wr_val = XW'(bth_pkg::PROLOGUE_TAG);
                n_state = bth_pkg::S_INIT1;
            end
            bth_pkg::S_INIT1: begin
                w_we = 1'b1; w_wr_byte = XW'(8); w_wr_val = XW'(bth_pkg::PROLOGUE_TAG);
                n_state = bth_pkg::S_INIT2;
            end
            bth_pkg::S_INIT2: begin
                w_we = 1'b1; w_wr_byte = XW'(12); w_wr_val = XW'(bth_pkg::EPILOGUE_TAG);
                n_kind   = bth_pkg::K_INIT;
                n_gbytes = w_chunk_x;
                n_state  = bth_pkg::S_GR_CHK;
            end
            bth_pkg::S_GR_CHK: begin
                if (w_grow_end > HEAP_BYTES) begin
                    if (r_kind == bth_pkg::K_INIT) begin
                        n_state = bth_pkg::S_IDLE;
                    end else begin
                        n_st    = bth_pkg::ST_NOMEM;
                        n_state = bth_pkg::S_DONE;
                    end
                end else begin
                    n_gsize = w_gsize;
                    n_bp    = r_brk;
                    n_state = bth_pkg::S_GR_W0;
                end
            end
            bth_pkg::S_GR_W0: begin
                w_we = 1'b1; w_wr_byte = r_bp - W4; w_wr_val = r_gsize;
                n_state = bth_pkg::S_GR_W1;
            end
            bth_pkg::S_GR_W1: begin
                w_we = 1'b1; w_wr_byte = r_bp + r_gsize - D8; w_wr_val = r_gsize;
                n_state = bth_pkg::S_GR_W2;
            end
            bth_pkg::S_GR_W2: begin
                // new epilogue just below the break
                w_we = 1'b1; w_wr_byte = r_bp + r_gsize - W4;
                w_wr_val = XW'(bth_pkg::EPILOGUE_TAG);
                n_brk   = r_bp + r_gsize;
                n_fsize = r_gsize;
                n_state = bth_pkg::S_MG_RDP;
            end
            bth_pkg::S_MG_RDP: begin
                w_rd_byte = r_bp - D8;
                n_state = bth_pkg::S_MG_RDN;
            end
            bth_pkg::S_MG_RDN: begin
                w_rd_byte = r_bp + r_fsize - W4;
                n_prev  = w_rdata;
                n_state = bth_pkg::S_MG_CK;
            end
            bth_pkg::S_MG_CK: begin
                n_bp    = w_start;
                n_fsize = w_total;
                n_state = bth_pkg::S_MG_W0;
            end
            bth_pkg::S_MG_W0: begin
                w_we = 1'b1; w_wr_byte = r_bp - W4; w_wr_val = r_fsize;
                n_state = bth_pkg::S_MG_W1;
            end
            bth_pkg::S_MG_W1: begin
                w_we = 1'b1; w_wr_byte = r_bp + r_fsize - D8; w_wr_val = r_fsize;
                // rover inside the merged block moves to its start
                if ((r_rover > r_bp) && (r_rover < (r_bp + r_fsize))) begin
                    n_rover = r_bp;
                end
                if (r_rel) begin
                    n_state = bth_pkg::S_DONE;
                end else if (r_kind == bth_pkg::K_INIT) begin
                    n_state = bth_pkg::S_IDLE;
                end else begin
                    n_state = bth_pkg::S_PL_W0;
                end
            end
            bth_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_addr = XW'(i_in_data.block_address);
                    n_req  = XW'(i_in_data.request_bytes);
                    n_res  = '0;
                    n_st   = bth_pkg::ST_NONE;
                    n_src  = '0;
                    n_dst  = '0;
                    n_cnt  = '0;
                    n_rel  = 1'b0;
                    n_b    = FIRST + D8;
                    n_old  = r_rover;
                    n_state = bth_pkg::S_DONE;
                    case (i_in_data.operation)
                        bth_pkg::OP_ALLOC: begin
                            if (i_in_data.request_bytes != 16'd0) begin
                                n_kind  = bth_pkg::K_ALLOC;
                                n_asize = w_asize_alloc;
                                n_state = bth_pkg::S_FF1_RD;
                            end
                        end
                        bth_pkg::OP_FREE: begin
                            n_kind  = bth_pkg::K_FREE;
                            n_state = bth_pkg::S_ISA_RD;
                        end
                        bth_pkg::OP_REALLOC: begin
                            if (i_in_data.block_address == 16'd0) begin
                                if (i_in_data.request_bytes != 16'd0) begin
                                    n_kind  = bth_pkg::K_ALLOC;
                                    n_asize = w_asize_alloc;
                                    n_state = bth_pkg::S_FF1_RD;
                                end
                            end else if (i_in_data.request_bytes == 16'd0) begin
                                n_kind  = bth_pkg::K_FREE;
                                n_state = bth_pkg::S_ISA_RD;
                            end else begin
                                n_kind  = bth_pkg::K_RMOVE;
                                n_asize = w_asize_real;
                                n_state = bth_pkg::S_ISA_RD;
                            end
                        end
                        default: begin
                            n_state = bth_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bth_pkg::S_ISA_RD: begin
                w_rd_byte = r_b - W4;
                if (r_b > r_addr) begin
                    n_ok    = 1'b0;
                    n_state = bth_pkg::S_ISA_END;
                end else begin
                    n_state = bth_pkg::S_ISA_CK;
                end
            end
            bth_pkg::S_ISA_CK: begin
                if (w_rsize == '0) begin
                    n_ok    = 1'b0;
                    n_state = bth_pkg::S_ISA_END;
                end else if (r_b == r_addr) begin
                    n_ok    = w_ralloc;
                    n_osize = w_rsize;
                    n_state = bth_pkg::S_ISA_END;
                end else begin
                    n_b     = r_b + w_rsize;
                    n_state = bth_pkg::S_ISA_RD;
                end
            end
            bth_pkg::S_ISA_END: begin
                if (r_kind == bth_pkg::K_FREE) begin
                    if (r_ok) begin
                        n_rel   = 1'b1;
                        n_state = bth_pkg::S_RL_W0;
                    end else begin
                        n_state = bth_pkg::S_DONE;
                    end
                end else if (!r_ok) begin
                    n_st    = bth_pkg::ST_NOMEM;
                    n_state = bth_pkg::S_DONE;
                end else if (r_asize <= r_osize) begin
                    n_kind  = bth_pkg::K_RSHR;
                    n_bp    = r_addr;
                    n_fsize = r_osize;
                    n_state = bth_pkg::S_PL_W0;
                end else begin
                    n_old   = r_rover;
                    n_state = bth_pkg::S_FF1_RD;
                end
            end
            bth_pkg::S_FF1_RD: begin
                w_rd_byte = r_rover - W4;
                n_state = bth_pkg::S_FF1_CK;
            end
            bth_pkg::S_FF1_CK: begin
                if (w_rsize == '0) begin
                    n_rover = FIRST;
                    n_state = bth_pkg::S_FF2_RD;
                end else if (w_fits) begin
                    n_bp    = r_rover;
                    n_fsize = w_rsize;
                    n_state = bth_pkg::S_PL_W0;
                end else begin
                    n_rover = r_rover + w_rsize;
                    n_state = bth_pkg::S_FF1_RD;
                end
            end
            bth_pkg::S_FF2_RD: begin
                w_rd_byte = r_rover - W4;
                // at or past the starting point the last read only steps the rover before the heap grows
                n_state = (r_rover < r_old) ? bth_pkg::S_FF2_CK : bth_pkg::S_FFE_CK;
            end
            bth_pkg::S_FF2_CK: begin
                if (w_fits) begin
                    n_bp    = r_rover;
                    n_fsize = w_rsize;
                    n_state = bth_pkg::S_PL_W0;
                end else if (w_rsize == '0) begin
                    n_gbytes = (w_chunk_x > r_asize) ? w_chunk_x : r_asize;
                    n_state  = bth_pkg::S_GR_CHK;
                end else begin
                    n_rover = r_rover + w_rsize;
                    n_state = bth_pkg::S_FF2_RD;
                end
            end
            bth_pkg::S_FFE_CK: begin
                n_rover  = r_rover + w_rsize;
                n_gbytes = (w_chunk_x > r_asize) ? w_chunk_x : r_asize;
                n_state  = bth_pkg::S_GR_CHK;
            end
            bth_pkg::S_PL_W0: begin
                w_we = 1'b1; w_wr_byte = r_bp - W4; w_wr_val = w_first_sz | XW'(1);
                n_state = bth_pkg::S_PL_W1;
            end
            bth_pkg::S_PL_W1: begin
                w_we = 1'b1; w_wr_byte = r_bp + w_first_sz - D8;
                w_wr_val = w_first_sz | XW'(1);
                n_res = r_bp[15:0];
                n_st  = bth_pkg::ST_GRANTED;
                if (w_split) begin
                    n_state = bth_pkg::S_PL_W2;
                end else if (r_kind == bth_pkg::K_RMOVE) begin
                    n_state = bth_pkg::S_RL_W0;
                end else begin
                    n_state = bth_pkg::S_DONE;
                end
                if (r_kind == bth_pkg::K_RMOVE) begin
                    n_rel = 1'b1;
                    n_src = r_addr[15:0];
                    n_dst = r_bp[15:0];
                    n_cnt = (r_req < w_cnt_full) ? r_req[15:0] : w_cnt_full[15:0];
                end
            end
            bth_pkg::S_PL_W2: begin
                w_we = 1'b1; w_wr_byte = r_bp + r_asize - W4; w_wr_val = w_rem;
                n_state = bth_pkg::S_PL_W3;
            end
            bth_pkg::S_PL_W3: begin
                w_we = 1'b1; w_wr_byte = r_bp + r_fsize - D8; w_wr_val = w_rem;
                n_state = (r_kind == bth_pkg::K_RMOVE) ? bth_pkg::S_RL_W0 : bth_pkg::S_DONE;
            end
            bth_pkg::S_RL_W0: begin
                w_we = 1'b1; w_wr_byte = r_addr - W4; w_wr_val = r_osize;
                n_state = bth_pkg::S_RL_W1;
            end
            bth_pkg::S_RL_W1: begin
                w_we = 1'b1; w_wr_byte = r_addr + r_osize - D8; w_wr_val = r_osize;
                n_bp    = r_addr;
                n_fsize = r_osize;
                n_state = bth_pkg::S_MG_RDP;
            end
            bth_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.result_address   = r_res;
                    n_out.status           = r_st;
                    n_out.copy_source      = r_src;
                    n_out.copy_destination = r_dst;
                    n_out.copy_bytes       = r_cnt;
                    n_out_valid = 1'b1;
                    n_state     = bth_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bth_pkg::S_IDLE;
            end
        endcase
    end

    `BTH_ASSERT_ALWAYS(a_brk_bound, (r_brk <= HEAP_BYTES) && (r_brk[2:0] == 3'b000), "bad break")
    `BTH_ASSERT_ALWAYS(a_rover_bound, (r_rover >= FIRST) && (r_rover[2:0] == 3'b000), "bad rover")
    `BTH_ASSERT_IMPLY(a_no_grant_empty,
        o_out_valid && (o_out_data.status != bth_pkg::ST_GRANTED),
        (o_out_data.result_address == 16'd0) && (o_out_data.copy_bytes == 16'd0),
        "refused request carries an address or copy")
    `BTH_ASSERT_NEXT(a_done_loads,
        (r_state == bth_pkg::S_DONE) && !r_out_valid,
        o_out_valid && (r_state == bth_pkg::S_IDLE),
        "finished request not loaded into output register")

endmodule
